@@ hw/rtl/rdbsop_pkg.sv @@
// ----------------------------------------------------------------------------
// rdbsop_pkg
// Shared item types and codes for the snapshot string object parser.
// ----------------------------------------------------------------------------
package rdbsop_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_data;
  } byte_item_t;

  typedef struct packed {
    logic [2:0]         result_kind;
    logic signed [31:0] value;
    logic [63:0]        declared_length;
    logic [63:0]        compressed_length;
    logic               last_of_object;
    logic [1:0]         error_code;
  } result_item_t;

  localparam logic [2:0] KIND_RAW   = 3'd0;
  localparam logic [2:0] KIND_INT   = 3'd1;
  localparam logic [2:0] KIND_EMPTY = 3'd2;
  localparam logic [2:0] KIND_COMP  = 3'd3;
  localparam logic [2:0] KIND_ERR   = 3'd4;

  localparam logic [1:0] ERR_NONE    = 2'd0;
  localparam logic [1:0] ERR_TRUNC   = 2'd1;
  localparam logic [1:0] ERR_LENFORM = 2'd2;
  localparam logic [1:0] ERR_ENC     = 2'd3;

  localparam logic [7:0] LEN_TYPE_MASK = 8'hC0;
  localparam logic [7:0] LEN_LOW_MASK  = 8'h3F;
  localparam logic [7:0] LEN_32BIT     = 8'h80;
  localparam logic [7:0] LEN_64BIT     = 8'h81;

  localparam logic [5:0] ENC_INT8  = 6'd0;
  localparam logic [5:0] ENC_INT16 = 6'd1;
  localparam logic [5:0] ENC_INT32 = 6'd2;
  localparam logic [5:0] ENC_LZF   = 6'd3;

endpackage

@@ hw/rtl/rdbsop_decode.sv @@
// ----------------------------------------------------------------------------
// rdbsop_decode
// Per-byte header/payload decode: parser state registers and the next-state
// and result logic for one accepted byte.
// ----------------------------------------------------------------------------
module rdbsop_decode (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      accept,
  input  rdbsop_pkg::byte_item_t    item,
  output logic                      res_valid,
  output rdbsop_pkg::result_item_t  res
);

  typedef enum logic [3:0] {
    PH_HDR       = 4'd0,
    PH_HDR_CONT  = 4'd1,
    PH_INT       = 4'd2,
    PH_CLEN      = 4'd3,
    PH_CLEN_CONT = 4'd4,
    PH_ULEN      = 4'd5,
    PH_ULEN_CONT = 4'd6,
    PH_RAW       = 4'd7,
    PH_LZF_DATA  = 4'd8
  } phase_t;

  function automatic phase_t cont_of(phase_t c);
    phase_t r;
    case (c)
      PH_CLEN: r = PH_CLEN_CONT;
      PH_ULEN: r = PH_ULEN_CONT;
      default: r = PH_HDR_CONT;
    endcase
    return r;
  endfunction

  phase_t      phase, phase_next;
  logic [3:0]  hdr_cnt, hdr_cnt_next;
  logic [63:0] len_acc, len_acc_next;
  logic [63:0] remaining, remaining_next;
  logic [63:0] comp_len, comp_len_next;
  logic [63:0] plain_len, plain_len_next;
  logic [31:0] int_acc, int_acc_next;
  logic [1:0]  int_width, int_width_next;

  logic [7:0]  b;
  logic        first;
  phase_t      first_ctx;
  logic        fin;
  phase_t      fin_ctx;
  logic [63:0] fin_len;
  logic        err;
  logic [1:0]  err_code;
  logic        clr;
  logic [63:0] acc_shift;
  logic [3:0]  cnt_dec;
  logic [63:0] rem_dec;
  logic [1:0]  int_idx;
  logic [2:0]  int_cnt;
  logic [2:0]  int_need;
  logic [31:0] int_new;

  assign b         = item.data_byte;
  assign acc_shift = {len_acc[55:0], b};
  assign cnt_dec   = (hdr_cnt != 4'd0) ? hdr_cnt - 4'd1 : 4'd0;
  assign rem_dec   = (remaining != 64'd0) ? remaining - 64'd1 : 64'd0;
  assign int_idx   = hdr_cnt[1:0];
  assign int_cnt   = {1'b0, int_idx} + 3'd1;
  assign int_need  = (int_width == 2'd0) ? 3'd1 : (int_width == 2'd1) ? 3'd2 : 3'd4;
  assign int_new   = int_acc | ({24'd0, b} << {int_idx, 3'b000});

  always_comb begin
    phase_next     = phase;
    hdr_cnt_next   = hdr_cnt;
    len_acc_next   = len_acc;
    remaining_next = remaining;
    comp_len_next  = comp_len;
    plain_len_next = plain_len;
    int_acc_next   = int_acc;
    int_width_next = int_width;
    first          = 1'b0;
    first_ctx      = PH_HDR;
    fin            = 1'b0;
    fin_ctx        = PH_HDR;
    fin_len        = 64'd0;
    err            = 1'b0;
    err_code       = rdbsop_pkg::ERR_NONE;
    clr            = 1'b0;
    res_valid      = 1'b0;
    res            = '0;

    if (item.end_of_data) begin
      if (phase != PH_HDR) begin
        err      = 1'b1;
        err_code = rdbsop_pkg::ERR_TRUNC;
      end
    end else begin
      case (phase)
        PH_HDR, PH_CLEN, PH_ULEN: begin
          first     = 1'b1;
          first_ctx = phase;
        end
        PH_HDR_CONT, PH_CLEN_CONT, PH_ULEN_CONT: begin
          len_acc_next = acc_shift;
          hdr_cnt_next = cnt_dec;
          if (cnt_dec == 4'd0) begin
            fin     = 1'b1;
            fin_len = acc_shift;
            fin_ctx = (phase == PH_CLEN_CONT) ? PH_CLEN :
                      (phase == PH_ULEN_CONT) ? PH_ULEN : PH_HDR;
          end
        end
        PH_INT: begin
          hdr_cnt_next = {1'b0, int_cnt};
          if (int_cnt < int_need) begin
            int_acc_next = int_new;
          end else begin
            clr                  = 1'b1;
            res_valid            = 1'b1;
            res.result_kind      = rdbsop_pkg::KIND_INT;
            res.last_of_object   = 1'b1;
            if (int_need == 3'd1) begin
              res.value = {{24{int_new[7]}}, int_new[7:0]};
            end else if (int_need == 3'd2) begin
              res.value = {{16{int_new[15]}}, int_new[15:0]};
            end else begin
              res.value = int_new;
            end
          end
        end
        PH_RAW, PH_LZF_DATA: begin
          remaining_next      = rem_dec;
          res_valid           = 1'b1;
          res.value           = {24'd0, b};
          res.declared_length = plain_len;
          res.last_of_object  = (rem_dec == 64'd0);
          if (phase == PH_RAW) begin
            res.result_kind = rdbsop_pkg::KIND_RAW;
          end else begin
            res.result_kind       = rdbsop_pkg::KIND_COMP;
            res.compressed_length = comp_len;
          end
          clr = (rem_dec == 64'd0);
        end
        default: begin
          phase_next     = PH_HDR;
          hdr_cnt_next   = 4'd0;
          len_acc_next   = 64'd0;
          remaining_next = 64'd0;
          comp_len_next  = 64'd0;
          plain_len_next = 64'd0;
          int_acc_next   = 32'd0;
          int_width_next = 2'd0;
          first          = 1'b1;
          first_ctx      = PH_HDR;
        end
      endcase
    end

    if (first) begin
      priority if ((b & rdbsop_pkg::LEN_TYPE_MASK) == 8'h00) begin
        fin     = 1'b1;
        fin_ctx = first_ctx;
        fin_len = {56'd0, b & rdbsop_pkg::LEN_LOW_MASK};
      end else if ((b & rdbsop_pkg::LEN_TYPE_MASK) == 8'h40) begin
        len_acc_next = {56'd0, b & rdbsop_pkg::LEN_LOW_MASK};
        hdr_cnt_next = 4'd1;
        phase_next   = cont_of(first_ctx);
      end else if (b == rdbsop_pkg::LEN_32BIT || b == rdbsop_pkg::LEN_64BIT) begin
        len_acc_next = 64'd0;
        hdr_cnt_next = (b == rdbsop_pkg::LEN_32BIT) ? 4'd4 : 4'd8;
        phase_next   = cont_of(first_ctx);
      end else if ((b & rdbsop_pkg::LEN_TYPE_MASK) != rdbsop_pkg::LEN_TYPE_MASK) begin
        err      = 1'b1;
        err_code = rdbsop_pkg::ERR_LENFORM;
      end else if (first_ctx != PH_HDR) begin
        // tag byte inside an LZF length: low bits read as the length
        fin     = 1'b1;
        fin_ctx = first_ctx;
        fin_len = {56'd0, b & rdbsop_pkg::LEN_LOW_MASK};
      end else begin
        case (b[5:0])
          rdbsop_pkg::ENC_INT8, rdbsop_pkg::ENC_INT16, rdbsop_pkg::ENC_INT32: begin
            int_width_next = b[1:0];
            int_acc_next   = 32'd0;
            hdr_cnt_next   = 4'd0;
            phase_next     = PH_INT;
          end
          rdbsop_pkg::ENC_LZF: begin
            phase_next = PH_CLEN;
          end
          default: begin
            err      = 1'b1;
            err_code = rdbsop_pkg::ERR_ENC;
          end
        endcase
      end
    end

    if (fin) begin
      hdr_cnt_next = 4'd0;
      len_acc_next = fin_len;
      case (fin_ctx)
        PH_CLEN: begin
          comp_len_next = fin_len;
          phase_next    = PH_ULEN;
        end
        PH_ULEN: begin
          plain_len_next = fin_len;
          if (comp_len == 64'd0) begin
            err      = 1'b1;
            err_code = rdbsop_pkg::ERR_ENC;
          end else begin
            remaining_next = comp_len;
            phase_next     = PH_LZF_DATA;
          end
        end
        default: begin
          if (fin_len == 64'd0) begin
            clr                = 1'b1;
            res_valid          = 1'b1;
            res.result_kind    = rdbsop_pkg::KIND_EMPTY;
            res.last_of_object = 1'b1;
          end else begin
            plain_len_next = fin_len;
            remaining_next = fin_len;
            phase_next     = PH_RAW;
          end
        end
      endcase
    end

    if (err) begin
      clr                = 1'b1;
      res_valid          = 1'b1;
      res                = '0;
      res.result_kind    = rdbsop_pkg::KIND_ERR;
      res.last_of_object = 1'b1;
      res.error_code     = err_code;
    end

    if (clr) begin
      phase_next     = PH_HDR;
      hdr_cnt_next   = 4'd0;
      len_acc_next   = 64'd0;
      remaining_next = 64'd0;
      comp_len_next  = 64'd0;
      plain_len_next = 64'd0;
      int_acc_next   = 32'd0;
      int_width_next = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_HDR;
      hdr_cnt   <= 4'd0;
      len_acc   <= 64'd0;
      remaining <= 64'd0;
      comp_len  <= 64'd0;
      plain_len <= 64'd0;
      int_acc   <= 32'd0;
      int_width <= 2'd0;
    end else if (accept) begin
      phase     <= phase_next;
      hdr_cnt   <= hdr_cnt_next;
      len_acc   <= len_acc_next;
      remaining <= remaining_next;
      comp_len  <= comp_len_next;
      plain_len <= plain_len_next;
      int_acc   <= int_acc_next;
      int_width <= int_width_next;
    end
  end

endmodule

@@ hw/rtl/rdbsop_out_buf.sv @@
// ----------------------------------------------------------------------------
// rdbsop_out_buf
// Two-entry result buffer; decouples the result stall from the byte side.
// ----------------------------------------------------------------------------
module rdbsop_out_buf (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  input  rdbsop_pkg::result_item_t  push_item,
  output logic                      full,
  output logic                      valid,
  input  logic                      stall,
  output rdbsop_pkg::result_item_t  item
);

  rdbsop_pkg::result_item_t entry [2];
  logic [1:0] count;
  logic       rd_ptr;
  logic       wr_ptr;
  logic       pop;

  assign full  = (count == 2'd2);
  assign valid = (count != 2'd0);
  assign pop   = valid && !stall;
  assign item  = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= 2'd0;
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

@@ hw/rtl/rdb_string_object_parser.sv @@
// ----------------------------------------------------------------------------
// rdb_string_object_parser
// Decodes string objects of a serialized snapshot byte stream.
// ----------------------------------------------------------------------------
// Byte channel (byte_valid/byte_stall/byte_item): one buffer byte per
// transfer, or an end-of-data mark. Result channel (result_valid/
// result_stall/result_item): zero or one result per byte, in stream order.
// Length headers (6/14/32/64-bit), integer tags and LZF length pairs are
// decoded in parser state; raw and compressed bytes pass through tagged with
// their lengths; empty strings give one marker; faults give an error item.
// Throughput: one byte per cycle while byte_stall is low. A result is written
// to the two-entry result buffer when the byte that causes it is transferred;
// decode is one level of logic between the parser state registers and buffer.
// Reset clears the parser to expect a header and empties the buffer.
// When the receiver stalls, the buffer absorbs up to two results; byte_stall
// is raised once both entries are held and drops as soon as one is taken.
// ----------------------------------------------------------------------------
module rdb_string_object_parser (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      byte_valid,
  output logic                      byte_stall,
  input  rdbsop_pkg::byte_item_t    byte_item,
  output logic                      result_valid,
  input  logic                      result_stall,
  output rdbsop_pkg::result_item_t  result_item
);

  logic                     accept;
  logic                     dec_valid;
  rdbsop_pkg::result_item_t dec_item;
  logic                     buf_full;

  assign byte_stall = buf_full;
  assign accept     = byte_valid && !buf_full;

  rdbsop_decode u_decode (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .item      (byte_item),
    .res_valid (dec_valid),
    .res       (dec_item)
  );

  rdbsop_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (accept && dec_valid),
    .push_item (dec_item),
    .full      (buf_full),
    .valid     (result_valid),
    .stall     (result_stall),
    .item      (result_item)
  );

endmodule
